// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, types and address helper for the text console writer.
// No dependencies; every other file of the block but tcw_ram imports this package.
package tcw_pkg;

	localparam int COLUMNS        = 80;
	localparam int ROWS           = 25;
	localparam int TERMINALS      = 4;

	localparam int CELLS_PER_TERM = COLUMNS * ROWS;
	localparam int SHIFT_CELLS    = CELLS_PER_TERM - COLUMNS;
	localparam int TOTAL_CELLS    = CELLS_PER_TERM * TERMINALS;
	localparam int ADDR_W         = $clog2(TOTAL_CELLS);
	localparam int CNT_W          = $clog2(TOTAL_CELLS + 1);
	localparam int ROW_W          = $clog2(ROWS);
	localparam int COL_W          = $clog2(COLUMNS);
	localparam int TERM_W         = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

	localparam int KIND_W         = 3;
	localparam int TERM_IN_W      = 2;
	localparam int CHAR_W         = 8;
	localparam int NIB_W          = 4;
	localparam int ROW_IN_W       = 5;
	localparam int COL_IN_W       = 7;
	localparam int SEEK_W         = 32;
	localparam int POS_W          = 11;
	localparam int COLOUR_W       = 8;
	localparam int CELL_W         = 16;
	localparam int IN_DATA_W      = 64;
	localparam int OUT_DATA_W     = 40;

	localparam int SEEK_STEPS     = 2;
	localparam int SEEK_FOLDS     = 5;

	localparam logic [KIND_W-1:0] KIND_PUT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_COLOUR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SEEK   = 3'd5;

	localparam logic [CHAR_W-1:0]   NEWLINE_CHAR = 8'd10;
	localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h0F;

	typedef struct packed {
		logic capture;
		logic exec;
		logic read_capture;
		logic init_sweep;
		logic clear_sweep;
		logic scroll_sweep;
		logic seek_step;
		logic load_result;
	} tcw_cmd_t;

	typedef struct packed {
		logic op_read;
		logic op_clear;
		logic op_seek;
		logic do_scroll;
		logic cnt_last;
		logic out_free;
	} tcw_status_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input int term, input int offset);
		cell_addr = ADDR_W'(term * CELLS_PER_TERM + offset);
	endfunction

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller of the text console writer: sequences accept, execute, sweeps and result.
// Depends on tcw_pkg for the command and status structs.
module tcw_ctrl import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tcw_status_t st,
	output tcw_cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_EXEC   = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_SCROLL = 8'b0001_0000,
		ST_CLEAR  = 8'b0010_0000,
		ST_SEEK   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} tcw_state_t;

	tcw_state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd              = '0;
		cmd.capture      = (state_q == ST_IDLE) && in_valid;
		cmd.exec         = (state_q == ST_EXEC);
		cmd.read_capture = (state_q == ST_READ);
		cmd.init_sweep   = (state_q == ST_INIT);
		cmd.clear_sweep  = (state_q == ST_CLEAR);
		cmd.scroll_sweep = (state_q == ST_SCROLL);
		cmd.seek_step    = (state_q == ST_SEEK);
		cmd.load_result  = (state_q == ST_DONE) && st.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (st.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (st.op_read) state_d = ST_READ;
				else if (st.op_clear) state_d = ST_CLEAR;
				else if (st.op_seek) state_d = ST_SEEK;
				else if (st.do_scroll) state_d = ST_SCROLL;
				else state_d = ST_DONE;
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_SCROLL, ST_CLEAR, ST_SEEK: begin
				if (st.cnt_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/tcw_dp.sv =====
// Datapath of the text console writer: item registers, cursors, colours,
// cell store, seek remainder unit and result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_dp import tcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcw_cmd_t              cmd,
	output tcw_status_t           st,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [KIND_W-1:0]     in_kind,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [KIND_W-1:0]    kind_q;
	logic [TERM_IN_W-1:0] term_q;
	logic [CHAR_W-1:0]    char_q;
	logic [NIB_W-1:0]     fg_q;
	logic [NIB_W-1:0]     bg_q;
	logic [ROW_IN_W-1:0]  row_q;
	logic [COL_IN_W-1:0]  col_q;
	logic [SEEK_W-1:0]    seek_q;
	logic [COL_W-1:0]     rem_q;
	logic [CELL_W-1:0]    cell_q;

	logic [ROW_W-1:0]     crow_q   [TERMINALS];
	logic [COL_W-1:0]     ccol_q   [TERMINALS];
	logic [COLOUR_W-1:0]  colour_q [TERMINALS];
	logic [CNT_W-1:0]     cnt_q;

	logic                 out_valid_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [COLOUR_W-1:0]  out_colour_q;
	logic [CELL_W-1:0]    out_cell_q;

	logic [TERM_W-1:0]    tidx;
	logic                 term_ok;
	logic                 in_range;
	logic [ADDR_W-1:0]    at_addr;
	logic [ROW_W-1:0]     cur_row, nxt_row;
	logic [COL_W-1:0]     cur_col, nxt_col;
	logic                 wrap, last_row;
	logic [COL_W-1:0]     nib_sum;
	logic [COL_W-1:0]     mod_acc;
	logic [COL_W-1:0]     rem_nxt;

	logic                 wr_en, rd_en;
	logic [ADDR_W-1:0]    wr_addr, rd_addr;
	logic [CELL_W-1:0]    wr_data, rd_data;

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (TOTAL_CELLS)
	) u_cells (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign tidx     = term_q[TERM_W-1:0];
	assign term_ok  = int'(term_q) < TERMINALS;
	assign in_range = (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS);
	assign at_addr  = cell_addr(int'(term_q), int'(row_q) * COLUMNS + int'(col_q));
	assign cur_row  = crow_q[tidx];
	assign cur_col  = ccol_q[tidx];

	// 16 is 1 mod 5: seek mod 80 is (sum of upper nibbles mod 5) * 16 + low nibble
	always_comb begin
		nib_sum = '0;
		for (int i = 1; i < SEEK_W / NIB_W; i++) begin
			nib_sum = nib_sum + COL_W'(seek_q[i*NIB_W +: NIB_W]);
		end
		mod_acc = rem_q;
		for (int k = 0; k < SEEK_FOLDS; k++) begin
			if (int'(mod_acc) >= (COLUMNS >> k)) begin
				mod_acc = mod_acc - COL_W'(COLUMNS >> k);
			end
		end
		rem_nxt = {mod_acc[COL_W-NIB_W-1:0], seek_q[NIB_W-1:0]};
	end

	always_comb begin
		last_row = (int'(cur_row) + 1) >= ROWS;
		if (char_q == NEWLINE_CHAR) begin
			wrap = 1'b1;
		end else begin
			wrap = (int'(cur_col) + 1) >= COLUMNS;
		end
		nxt_row = cur_row;
		nxt_col = cur_col + 1'b1;
		if (wrap) begin
			nxt_col = '0;
			nxt_row = last_row ? ROW_W'(ROWS - 1) : cur_row + 1'b1;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.init_sweep) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[ADDR_W-1:0];
		end
		if (cmd.clear_sweep) begin
			wr_en   = 1'b1;
			wr_addr = cell_addr(int'(term_q), int'(cnt_q));
		end
		if (cmd.scroll_sweep) begin
			if (int'(cnt_q) < SHIFT_CELLS) begin
				rd_en   = 1'b1;
				rd_addr = cell_addr(int'(term_q), int'(cnt_q) + COLUMNS);
			end
			if (cnt_q != '0) begin
				wr_en   = 1'b1;
				wr_addr = cell_addr(int'(term_q), int'(cnt_q) - 1);
				wr_data = (int'(cnt_q) <= SHIFT_CELLS) ? rd_data : '0;
			end
		end
		if (cmd.exec && term_ok) begin
			case (kind_q)
				KIND_PUT: begin
					if (char_q != NEWLINE_CHAR) begin
						wr_en   = 1'b1;
						wr_addr = cell_addr(int'(term_q),
						                    int'(cur_row) * COLUMNS + int'(cur_col));
						wr_data = {colour_q[tidx], char_q};
					end
				end
				KIND_WRITE: begin
					wr_en   = in_range;
					wr_addr = at_addr;
					wr_data = {bg_q, fg_q, char_q};
				end
				KIND_READ: begin
					rd_en   = in_range;
					rd_addr = at_addr;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		st.op_read   = term_ok && (kind_q == KIND_READ);
		st.op_clear  = term_ok && (kind_q == KIND_CLEAR);
		st.op_seek   = term_ok && (kind_q == KIND_SEEK);
		st.do_scroll = term_ok && (kind_q == KIND_PUT) && wrap && last_row;
		st.cnt_last  = (cmd.init_sweep   && (cnt_q == CNT_W'(TOTAL_CELLS - 1))) ||
		               (cmd.clear_sweep  && (cnt_q == CNT_W'(CELLS_PER_TERM - 1))) ||
		               (cmd.scroll_sweep && (cnt_q == CNT_W'(CELLS_PER_TERM))) ||
		               (cmd.seek_step    && (cnt_q == CNT_W'(SEEK_STEPS - 1)));
		st.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TERMINALS; i++) begin
				crow_q[i]   <= '0;
				ccol_q[i]   <= '0;
				colour_q[i] <= RESET_COLOUR;
			end
		end else begin
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.init_sweep || cmd.clear_sweep || cmd.scroll_sweep ||
			             cmd.seek_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.exec && term_ok) begin
				case (kind_q)
					KIND_PUT: begin
						crow_q[tidx] <= nxt_row;
						ccol_q[tidx] <= nxt_col;
					end
					KIND_COLOUR: begin
						colour_q[tidx] <= {bg_q, fg_q};
					end
					KIND_CLEAR: begin
						crow_q[tidx]   <= '0;
						ccol_q[tidx]   <= '0;
						colour_q[tidx] <= RESET_COLOUR;
					end
					default: begin
					end
				endcase
			end
			if (cmd.seek_step && st.cnt_last) begin
				ccol_q[tidx] <= rem_nxt;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			term_q <= in_data[1:0];
			char_q <= in_data[9:2];
			fg_q   <= in_data[13:10];
			bg_q   <= in_data[17:14];
			row_q  <= in_data[22:18];
			col_q  <= in_data[29:23];
			seek_q <= in_data[61:30];
			rem_q  <= '0;
			cell_q <= '0;
		end
		if (cmd.seek_step) begin
			rem_q <= nib_sum;
		end
		if (cmd.read_capture) begin
			cell_q <= in_range ? rd_data : '0;
		end
		if (cmd.load_result) begin
			if (term_ok) begin
				out_pos_q    <= POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
				out_colour_q <= colour_q[tidx];
			end else begin
				out_pos_q    <= '0;
				out_colour_q <= '0;
			end
			out_cell_q <= cell_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {5'b0, out_cell_q, out_colour_q, out_pos_q};

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer top level: multi-terminal 80x25 text console.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (which holds the tcw_ram cell store).
//
// Usage:
//   Input channel s_axis: one operation per transfer; tuser is the kind
//   (put char, write at, read at, set colour, clear, seek), tdata the operands.
//   Output channel m_axis: exactly one result per input item, in order.
// Sequence (from one accept to the next; the result turns valid in the same
//   cycle as the next item can be accepted):
//   put char, write at, set colour, seek-free ops: execute, then result.
//   read at: execute, then a registered read of the cell store, then result.
//   seek: execute, then nibble fold of the offset then a mod-5 reduction.
//   clear: one cell of the terminal per cycle.
//   put char that scrolls: one cell copied per cycle through the
//   single write port of the cell store, bottom row zeroed in the same sweep.
// Reset: cursors go to (0,0), colours to white on black, then the cell store
//   is zeroed one cell a cycle while s_axis_tready stays low.
// Stall: the result waits in the output register; a new item can be taken
//   meanwhile and its result holds back until the register frees.
module text_console_writer import tcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// terminal, character, foreground, background, row, column, seek, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [KIND_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// cursor_pos, current_colour, cell_value, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	tcw_cmd_t    cmd;
	tcw_status_t st;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tcw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while previous item still in work");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> m_axis_tvalid)
		else $error("result load did not raise output valid");

	a_single_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec, cmd.read_capture, cmd.init_sweep, cmd.clear_sweep,
		          cmd.scroll_sweep, cmd.seek_step}))
		else $error("more than one datapath phase active");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> int'(m_axis_tdata[POS_W-1:0]) < CELLS_PER_TERM)
		else $error("cursor position beyond terminal");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for text_console_writer: directed and random console operations on
// the stream input, results checked against an in-bench console predictor.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb;
	import tcw_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 2100;
	localparam int RANDOM_ITEMS   = 1900;

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic [TERM_IN_W-1:0] term;
		logic [CHAR_W-1:0]    ch;
		logic [NIB_W-1:0]     fg;
		logic [NIB_W-1:0]     bg;
		logic [ROW_IN_W-1:0]  row;
		logic [COL_IN_W-1:0]  col;
		logic [SEEK_W-1:0]    seek;
	} console_op_t;

	typedef struct {
		logic [POS_W-1:0]    pos;
		logic [COLOUR_W-1:0] colour;
		logic [CELL_W-1:0]   cell_val;
	} console_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [CELL_W-1:0]   screen [TERMINALS][CELLS_PER_TERM];
	int                  cur_row [TERMINALS];
	int                  cur_col [TERMINALS];
	logic [COLOUR_W-1:0] colour_reg [TERMINALS];

	console_view_t expected_views[$];
	int  mismatches = 0;
	int  results_seen = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1'b1;
	bit  hold_req = 1'b0;

	text_console_writer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic void wipe_terminal(int t);
		for (int i = 0; i < CELLS_PER_TERM; i++)
			screen[t][i] = '0;
		cur_row[t] = 0;
		cur_col[t] = 0;
		colour_reg[t] = RESET_COLOUR;
	endfunction

	function automatic void next_line(int t);
		cur_col[t] = 0;
		if (cur_row[t] + 1 >= ROWS) begin
			for (int i = 0; i < CELLS_PER_TERM - COLUMNS; i++)
				screen[t][i] = screen[t][i + COLUMNS];
			for (int i = CELLS_PER_TERM - COLUMNS; i < CELLS_PER_TERM; i++)
				screen[t][i] = '0;
			cur_row[t] = ROWS - 1;
		end else begin
			cur_row[t] = cur_row[t] + 1;
		end
	endfunction

	function automatic console_view_t apply_op(console_op_t op);
		console_view_t v;
		int t;
		int idx;
		bit in_range;
		t = int'(op.term);
		v.pos = '0;
		v.colour = '0;
		v.cell_val = '0;
		if (t >= TERMINALS)
			return v;
		in_range = (op.row < ROWS) && (op.col < COLUMNS);
		idx = int'(op.row) * COLUMNS + int'(op.col);
		case (op.kind)
			KIND_PUT: begin
				if (op.ch == NEWLINE_CHAR) begin
					next_line(t);
				end else begin
					screen[t][cur_row[t] * COLUMNS + cur_col[t]] = {colour_reg[t], op.ch};
					if (cur_col[t] + 1 >= COLUMNS)
						next_line(t);
					else
						cur_col[t] = cur_col[t] + 1;
				end
			end
			KIND_WRITE:  if (in_range) screen[t][idx] = {op.bg, op.fg, op.ch};
			KIND_READ:   if (in_range) v.cell_val = screen[t][idx];
			KIND_COLOUR: colour_reg[t] = {op.bg, op.fg};
			KIND_CLEAR:  wipe_terminal(t);
			KIND_SEEK:   cur_col[t] = op.seek % COLUMNS;
			default: ;
		endcase
		v.pos = POS_W'(cur_row[t] * COLUMNS + cur_col[t]);
		v.colour = colour_reg[t];
		return v;
	endfunction

	function automatic console_op_t make_op(logic [KIND_W-1:0] kind, int term, int ch,
			int fg, int bg, int row, int col, logic [SEEK_W-1:0] seek);
		console_op_t op;
		op.kind = kind;
		op.term = TERM_IN_W'(term);
		op.ch   = CHAR_W'(ch);
		op.fg   = NIB_W'(fg);
		op.bg   = NIB_W'(bg);
		op.row  = ROW_IN_W'(row);
		op.col  = COL_IN_W'(col);
		op.seek = seek;
		return op;
	endfunction

	function automatic console_op_t random_op();
		console_op_t op;
		int pick;
		op.term = ($urandom_range(0, 1) != 0) ? TERM_IN_W'(0) : TERM_IN_W'($urandom_range(0, 3));
		op.ch   = CHAR_W'($urandom_range(0, 255));
		op.fg   = NIB_W'($urandom_range(0, 15));
		op.bg   = NIB_W'($urandom_range(0, 15));
		op.seek = $urandom();
		op.row  = ($urandom_range(0, 9) != 0) ? ROW_IN_W'($urandom_range(0, ROWS - 1))
			: ROW_IN_W'($urandom_range(0, 31));
		op.col  = ($urandom_range(0, 9) != 0) ? COL_IN_W'($urandom_range(0, COLUMNS - 1))
			: COL_IN_W'($urandom_range(0, 127));
		pick = $urandom_range(0, 199);
		if (pick < 100) begin
			op.kind = KIND_PUT;
			if ($urandom_range(0, 3) == 0)
				op.ch = NEWLINE_CHAR;
		end else if (pick < 125) begin
			op.kind = KIND_WRITE;
		end else if (pick < 155) begin
			op.kind = KIND_READ;
			if ($urandom_range(0, 1) != 0 && op.term < TERMINALS)
				op.row = ROW_IN_W'(cur_row[op.term]);
		end else if (pick < 167) begin
			op.kind = KIND_COLOUR;
		end else if (pick < 168) begin
			op.kind = KIND_CLEAR;
		end else if (pick < 184) begin
			op.kind = KIND_SEEK;
		end else begin
			op.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
		end
		return op;
	endfunction

	task automatic send_op(input console_op_t op);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, op.seek, op.col, op.row, op.bg, op.fg, op.ch, op.term};
		s_axis_tuser  <= op.kind;
		do @(posedge clk); while (!s_axis_tready);
		expected_views.push_back(apply_op(op));
	endtask

	task automatic report_mismatch(input string msg);
		$display("tb: result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_view(input logic [OUT_DATA_W-1:0] d);
		console_view_t want;
		if (expected_views.size() == 0) begin
			report_mismatch("result with no item pending");
			return;
		end
		want = expected_views.pop_front();
		if (d[POS_W-1:0] !== want.pos)
			report_mismatch($sformatf("cursor_pos %0d, want %0d", d[POS_W-1:0], want.pos));
		if (d[POS_W +: COLOUR_W] !== want.colour)
			report_mismatch($sformatf("current_colour %h, want %h",
				d[POS_W +: COLOUR_W], want.colour));
		if (d[POS_W + COLOUR_W +: CELL_W] !== want.cell_val)
			report_mismatch($sformatf("cell_value %h, want %h",
				d[POS_W + COLOUR_W +: CELL_W], want.cell_val));
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			stall = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				check_view(m_axis_tdata);
				if (idle_on)
					stall = $urandom_range(0, 4);
			end
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_edges();
		send_op(make_op(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_PUT, 0, 8'h48, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_PUT, 0, 8'hFF, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_PUT, 0, 8'h00, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_PUT, 0, NEWLINE_CHAR, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_COLOUR, 0, 0, 15, 15, 0, 0, 0));
		send_op(make_op(KIND_PUT, 0, 8'h80, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_COLOUR, 0, 0, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_WRITE, 0, 8'hFF, 15, 15, ROWS - 1, COLUMNS - 1, 0));
		send_op(make_op(KIND_WRITE, 0, 8'h00, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_WRITE, 0, 8'h55, 3, 9, ROWS, 0, 0));
		send_op(make_op(KIND_WRITE, 0, 8'hAA, 12, 6, 31, 127, 0));
		send_op(make_op(KIND_WRITE, 0, 8'h33, 5, 10, 0, COLUMNS, 0));
		send_op(make_op(KIND_READ, 0, 0, 0, 0, ROWS - 1, COLUMNS - 1, 0));
		send_op(make_op(KIND_READ, 0, 0, 0, 0, 0, 1, 0));
		send_op(make_op(KIND_READ, 0, 0, 0, 0, 31, 127, 0));
		send_op(make_op(KIND_READ, 0, 0, 0, 0, ROWS, 0, 0));
		send_op(make_op(KIND_SEEK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_op(make_op(KIND_SEEK, 0, 0, 0, 0, 0, 0, COLUMNS - 1));
		send_op(make_op(KIND_PUT, 0, 8'h5A, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_SPARE_LO, 0, 8'hFF, 15, 15, 31, 127, 32'hFFFF_FFFF));
		send_op(make_op(KIND_SPARE_HI, 3, 0, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_READ, 0, 0, 0, 0, ROWS - 1, COLUMNS - 1, 0));
		send_op(make_op(KIND_PUT, 3, 8'h7E, 0, 0, 0, 0, 0));
	endtask

	task automatic test_scroll();
		send_op(make_op(KIND_COLOUR, 1, 0, 2, 1, 0, 0, 0));
		send_op(make_op(KIND_WRITE, 1, 8'h4D, 4, 7, 1, 5, 0));
		repeat (ROWS - 1)
			send_op(make_op(KIND_PUT, 1, NEWLINE_CHAR, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_SEEK, 1, 0, 0, 0, 0, 0, COLUMNS - 1));
		send_op(make_op(KIND_PUT, 1, 8'h78, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_READ, 1, 0, 0, 0, 0, 5, 0));
		send_op(make_op(KIND_READ, 1, 0, 0, 0, ROWS - 2, COLUMNS - 1, 0));
		send_op(make_op(KIND_READ, 1, 0, 0, 0, ROWS - 1, COLUMNS - 1, 0));
		send_op(make_op(KIND_PUT, 1, 8'h79, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_PUT, 1, NEWLINE_CHAR, 0, 0, 0, 0, 0));
		send_op(make_op(KIND_READ, 1, 0, 0, 0, ROWS - 2, 0, 0));
		send_op(make_op(KIND_READ, 1, 0, 0, 0, ROWS - 3, COLUMNS - 1, 0));
		send_op(make_op(KIND_CLEAR, 1, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_req = 1'b1;
		repeat (16)
			send_op(random_op());
		idle_on = 1'b1;
	endtask

	task automatic test_random();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_op(random_op());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int t = 0; t < TERMINALS; t++)
			wipe_terminal(t);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_scroll();
		test_backpressure();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_views.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
